// File: rtl/tre_pkg.sv
// Shared types, constants and the exp2 fraction table of the ramp envelope core.
package tre_pkg;

  localparam int POSITION_BITS   = 24;
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int IDX_BITS        = $clog2(EXP_TABLE_DEPTH);
  localparam int SAMPLE_BITS     = 16;
  localparam int BASE_BITS       = 20;
  localparam int EXP_BITS        = 32;
  localparam int PROD_BITS       = BASE_BITS + EXP_BITS;
  localparam int LEN_BITS        = BASE_BITS + 2;
  localparam int FRAC_BITS       = 14;
  localparam int QUOT_BITS       = 16;
  localparam int CFG_IDX_BITS    = 1;
  localparam int CFG_DATA_BITS   = BASE_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_DURATION = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BIPOLAR_MODE  = 1'b1;

  localparam logic [BASE_BITS-1:0]   BASE_DURATION_RST = BASE_BITS'(48000);
  localparam logic signed [16:0]     TRIGGER_RISE      = 17'sd16384;
  localparam logic [POSITION_BITS-1:0] POS_MAX         = '1;

  // 2^(2^-k) in Q1.30, k = 1 .. 16
  localparam logic [31:0] ROOT_Q30 [16] = '{
    32'd1518500250, 32'd1276901417, 32'd1170923762, 32'd1121280436,
    32'd1097253708, 32'd1085434106, 32'd1079572136, 32'd1076653033,
    32'd1075196443, 32'd1074468888, 32'd1074105294, 32'd1073923544,
    32'd1073832680, 32'd1073787251, 32'd1073764537, 32'd1073753181
  };

  typedef logic [EXP_BITS-1:0] exp_tab_t [EXP_TABLE_DEPTH];

  // Evaluated at elaboration only
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] q;
    logic [63:0] t;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      q = (64'(i) << 16) / EXP_TABLE_DEPTH;
      t = 64'd1 << 30;
      for (int k = 0; k < 16; k++) begin
        if (q[15-k]) begin
          t = (t * 64'(ROOT_Q30[k]) + (64'd1 << 29)) >> 30;
        end
      end
      tab[i] = t[EXP_BITS-1:0];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MUL,
    ST_CMP,
    ST_DIV,
    ST_DONE
  } tre_state_e;

  typedef struct packed {
    logic                start;
    logic [LEN_BITS-1:0] numer;
    logic [LEN_BITS-1:0] denom;
  } div_req_t;

endpackage

// File: rtl/tre_stream_if.sv
// Valid/ready channels for frame requests and envelope results.
interface tre_in_if;
  import tre_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] trigger_level;
  logic                          trigger_present;
  logic signed [SAMPLE_BITS-1:0] duration_mod;
  logic                          mod_present;

  modport source (output valid, trigger_level, trigger_present, duration_mod, mod_present,
                  input ready);
  modport sink   (input valid, trigger_level, trigger_present, duration_mod, mod_present,
                  output ready);
endinterface

interface tre_out_if;
  import tre_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] envelope_sample;

  modport source (output valid, envelope_sample, input ready);
  modport sink   (input valid, envelope_sample, output ready);
endinterface

// File: rtl/tre_div.sv
// Restoring divider, one quotient bit per cycle, for numerator below divisor.
module tre_div
  import tre_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  div_req_t             req_i,
  output logic                 done_o,
  output logic [QUOT_BITS-1:0] quot_o
);

  localparam int CNT_BITS = $clog2(QUOT_BITS);

  logic                busy_q, done_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic [LEN_BITS-1:0] rem_q, den_q;
  logic [QUOT_BITS-1:0] quot_q;
  logic [LEN_BITS:0]   shifted;
  logic [LEN_BITS:0]   diff;
  logic                take;

  assign shifted = {rem_q, 1'b0};
  assign diff    = shifted - {1'b0, den_q};
  assign take    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_BITS'(QUOT_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.numer;
      den_q  <= req_i.denom;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= take ? diff[LEN_BITS-1:0] : shifted[LEN_BITS-1:0];
      quot_q <= {quot_q[QUOT_BITS-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: rtl/triggered_ramp_envelope_core.sv
// Triggered ramp envelope generator: trigger detect, modulated length and ramp divide.
// One frame is taken per request and gives one envelope sample. Each frame passes the
// exp2 table read, the length multiply and the length compare; when the ramp has ended
// or its length is zero it then goes to the output register, and while the ramp runs it
// first passes the restoring divider, whose quotient is collected before the output
// register is loaded. A new frame is accepted as soon as the previous one has reached
// the output register, even while that result is still waiting to be taken.
module triggered_ramp_envelope_core
  import tre_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  tre_in_if.sink                   in_if,
  tre_out_if.source                out_if,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  tre_state_e state_q, state_d;

  logic [BASE_BITS-1:0]     base_q;
  logic                     bipolar_q;
  logic [POSITION_BITS-1:0] pos_q;
  logic [SAMPLE_BITS-1:0]   held_q;
  logic [SAMPLE_BITS-1:0]   prev_q;
  logic [SAMPLE_BITS-1:0]   out_q;
  logic                     out_valid_q;

  logic [SAMPLE_BITS-1:0]   mod_u_q;
  logic                     mod_en_q;
  logic [EXP_BITS-1:0]      exp_q;
  logic [PROD_BITS-1:0]     prod_q;

  logic                     accept;
  logic                     load_out;
  logic                     rise;
  logic signed [16:0]       trig_diff;
  logic [5:0]               shamt;
  logic [PROD_BITS-1:0]     prod_sh;
  logic [LEN_BITS-1:0]      len;
  logic                     in_ramp;
  div_req_t                 div_req;
  logic                     div_done;
  logic [QUOT_BITS-1:0]     quot;

  assign accept    = in_if.valid && in_if.ready;
  assign trig_diff = 17'(in_if.trigger_level) - 17'(signed'(prev_q));
  assign rise      = in_if.trigger_present && (trig_diff > TRIGGER_RISE);

  assign shamt   = 6'd32 - 6'(mod_u_q[SAMPLE_BITS-1:FRAC_BITS]);
  assign prod_sh = prod_q >> shamt;
  assign len     = mod_en_q ? prod_sh[LEN_BITS-1:0] : LEN_BITS'(base_q);
  // compared at the width of both so either may be the wider one
  assign in_ramp = (POSITION_BITS + LEN_BITS)'(pos_q) < (POSITION_BITS + LEN_BITS)'(len);

  always_comb begin
    state_d       = state_q;
    in_if.ready   = 1'b0;
    load_out      = 1'b0;
    div_req.start = 1'b0;
    div_req.numer = LEN_BITS'(pos_q);
    div_req.denom = len;
    case (state_q)
      ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: state_d = ST_MUL;
      ST_MUL:  state_d = ST_CMP;
      ST_CMP: begin
        if (in_ramp) begin
          div_req.start = 1'b1;
          state_d       = ST_DIV;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_if.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= BASE_DURATION_RST;
      bipolar_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE_DURATION: base_q    <= cfg_data_i;
        CFG_BIPOLAR_MODE:  bipolar_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      held_q      <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept && in_if.trigger_present) begin
        prev_q <= in_if.trigger_level;
      end
      if (accept && rise) begin
        pos_q  <= '0;
        held_q <= '0;
      end else if (load_out && pos_q != POS_MAX) begin
        pos_q <= pos_q + 1'b1;
      end
      if (state_q == ST_DIV && div_done) begin
        held_q <= bipolar_q ? {~quot[QUOT_BITS-1], quot[QUOT_BITS-2:0]}
                            : {1'b0, quot[QUOT_BITS-1:1]};
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mod_u_q  <= {~in_if.duration_mod[SAMPLE_BITS-1], in_if.duration_mod[SAMPLE_BITS-2:0]};
      mod_en_q <= in_if.mod_present;
    end
    if (state_q == ST_LOOK) begin
      exp_q <= EXP_TAB[mod_u_q[FRAC_BITS-1 -: IDX_BITS]];
    end
    if (state_q == ST_MUL) begin
      prod_q <= PROD_BITS'(base_q) * PROD_BITS'(exp_q);
    end
    if (load_out) begin
      out_q <= held_q;
    end
  end

  tre_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  assign out_if.valid           = out_valid_q;
  assign out_if.envelope_sample = out_q;

endmodule
